FILE: rtl/core/tsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsd_pkg
// Types, constants and helper functions shared by the text stream decoder.
// ----------------------------------------------------------------------------
package tsd_pkg;

    // input encodings
    typedef enum logic [1:0] {
        ENC_UTF8        = 2'd0,
        ENC_UTF16LE     = 2'd1,
        ENC_UTF16BE     = 2'd2,
        ENC_UNSUPPORTED = 2'd3
    } encoding_t;

    // configuration register indexes
    localparam logic [1:0] REG_ENCODING     = 2'd0;
    localparam logic [1:0] REG_START_OFFSET = 2'd1;
    localparam logic [1:0] REG_START_LINE   = 2'd2;

    // code units
    localparam logic [15:0] REPL_UNIT       = 16'hFFFD;
    localparam logic [15:0] NEWLINE_UNIT    = 16'h000A;
    localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_LAST   = 16'hDFFF;

    // utf-8 code point limits
    localparam logic [20:0] MIN_TWO_BYTE   = 21'h00080;
    localparam logic [20:0] MIN_THREE_BYTE = 21'h00800;
    localparam logic [20:0] MIN_FOUR_BYTE  = 21'h10000;
    localparam logic [20:0] BMP_LAST       = 21'h0FFFF;
    localparam logic [20:0] SURR_FIRST     = 21'h0D800;
    localparam logic [20:0] SURR_LAST      = 21'h0DFFF;

    // utf-8 byte classes
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_TAG    = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_TAG   = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_TAG   = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_TAG   = 8'hF0;

    // line counter
    localparam logic [31:0] LINE_FIRST = 32'd1;
    localparam logic [31:0] LINE_MAX   = 32'hFFFF_FFFF;

    // one result word
    typedef struct packed {
        logic [15:0] code_unit;
        logic [31:0] unit_offset;
        logic [31:0] line_number;
        logic        last_of_run;
    } result_t;

    // up to two result words caused by one input byte
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } result_pair_t;

    function automatic logic is_high_surrogate(input logic [15:0] unit);
        return (unit >= HIGH_SURR_FIRST) && (unit <= HIGH_SURR_LAST);
    endfunction

    function automatic logic is_low_surrogate(input logic [15:0] unit);
        return (unit >= LOW_SURR_FIRST) && (unit <= LOW_SURR_LAST);
    endfunction

    // byte order of a utf-16 unit
    function automatic logic [15:0] make_unit(input encoding_t enc,
                                              input logic [7:0] first_byte,
                                              input logic [7:0] second_byte);
        if (enc == ENC_UTF16LE)
        begin
            return {second_byte, first_byte};
        end
        return {first_byte, second_byte};
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/tsd_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsd_decoder
// Running decode state, configuration registers and the single-pass decode
// of one byte into at most two result words.
// ----------------------------------------------------------------------------
module tsd_decoder #(
    parameter int OFFSET_BITS = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire logic                 accept,
    input  wire logic [7:0]           byte_in,
    input  wire logic                 end_of_text,
    output tsd_pkg::result_pair_t     pair
);
    import tsd_pkg::*;

    // configuration
    encoding_t               encoding_reg;
    logic [31:0]             start_offset_reg;
    logic [31:0]             start_line_reg;

    // decode state
    logic                    collecting_reg,   collecting_next;
    logic [1:0]              bytes_needed_reg, bytes_needed_next;
    logic [20:0]             partial_reg,      partial_next;
    logic [1:0]              min_class_reg,    min_class_next;
    logic [7:0]              held_byte_reg,    held_byte_next;
    logic [1:0]              held_count_reg,   held_count_next;
    logic [OFFSET_BITS-1:0]  seq_start_reg,    seq_start_next;
    logic [OFFSET_BITS-1:0]  position_reg,     position_next;
    logic [31:0]             line_reg,         line_next;

    // per-byte decode
    logic [OFFSET_BITS-1:0]  pos_prev;
    logic                    is_ascii, is_cont, is_lead2, is_lead3, is_lead4, is_bad_lead;
    logic [1:0]              lead_need;
    logic [1:0]              lead_class;
    logic [20:0]             lead_value;
    logic [20:0]             cont_value;
    logic [20:0]             cont_min;
    logic                    cont_bad;
    logic [15:0]             cont_unit;
    logic [15:0]             pair_unit;
    logic [15:0]             unit_w [2];
    logic [OFFSET_BITS-1:0]  offs_w [2];
    logic [1:0]              count_w;
    logic                    fresh_w;

    // line bookkeeping
    logic                    nl_first, nl_second;
    logic [31:0]             line_inc1, line_inc2, line_second;

    assign pos_prev = position_reg - OFFSET_BITS'(1);

    // utf-8 byte classes
    assign is_ascii    = byte_in < ASCII_LIMIT;
    assign is_cont     = (byte_in & CONT_MASK)  == CONT_TAG;
    assign is_lead2    = (byte_in & LEAD2_MASK) == LEAD2_TAG;
    assign is_lead3    = (byte_in & LEAD3_MASK) == LEAD3_TAG;
    assign is_lead4    = (byte_in & LEAD4_MASK) == LEAD4_TAG;
    assign is_bad_lead = !is_ascii && !is_lead2 && !is_lead3 && !is_lead4;

    // lead byte payload and length
    always_comb
    begin
        lead_need  = 2'd1;
        lead_class = 2'd0;
        lead_value = {16'd0, byte_in[4:0]};
        if (is_lead3)
        begin
            lead_need  = 2'd2;
            lead_class = 2'd1;
            lead_value = {17'd0, byte_in[3:0]};
        end
        else if (is_lead4)
        begin
            lead_need  = 2'd3;
            lead_class = 2'd2;
            lead_value = {18'd0, byte_in[2:0]};
        end
    end

    // continuation byte and range check of a finished sequence
    assign cont_value = {partial_reg[14:0], byte_in[5:0]};
    assign cont_min   = (min_class_reg == 2'd0) ? MIN_TWO_BYTE :
                        (min_class_reg == 2'd1) ? MIN_THREE_BYTE : MIN_FOUR_BYTE;
    assign cont_bad   = (cont_value < cont_min) || (cont_value > BMP_LAST) ||
                        ((cont_value >= SURR_FIRST) && (cont_value <= SURR_LAST));
    assign cont_unit  = cont_bad ? REPL_UNIT : cont_value[15:0];

    // utf-16 unit from the held byte and this one
    assign pair_unit = make_unit(encoding_reg, held_byte_reg, byte_in);

    // decode of one byte
    always_comb
    begin
        count_w           = 2'd0;
        unit_w[0]         = '0;
        unit_w[1]         = '0;
        offs_w[0]         = '0;
        offs_w[1]         = '0;
        fresh_w           = 1'b0;
        collecting_next   = collecting_reg;
        bytes_needed_next = bytes_needed_reg;
        partial_next      = partial_reg;
        min_class_next    = min_class_reg;
        held_byte_next    = held_byte_reg;
        held_count_next   = held_count_reg;
        seq_start_next    = seq_start_reg;

        case (encoding_reg)
            ENC_UTF8:
            begin
                if (collecting_reg)
                begin
                    if (is_cont)
                    begin
                        partial_next      = cont_value;
                        bytes_needed_next = bytes_needed_reg - 2'd1;
                        if (bytes_needed_reg == 2'd1)
                        begin
                            collecting_next = 1'b0;
                            unit_w[0]       = cont_unit;
                            offs_w[0]       = seq_start_reg;
                            count_w         = 2'd1;
                        end
                    end
                    else
                    begin
                        // broken sequence, then the byte starts afresh
                        collecting_next = 1'b0;
                        unit_w[0]       = REPL_UNIT;
                        offs_w[0]       = seq_start_reg;
                        count_w         = 2'd1;
                        fresh_w         = 1'b1;
                    end
                end
                else
                begin
                    fresh_w = 1'b1;
                end

                if (fresh_w)
                begin
                    if (is_ascii || is_bad_lead)
                    begin
                        unit_w[count_w[0]] = is_ascii ? {8'h00, byte_in} : REPL_UNIT;
                        offs_w[count_w[0]] = position_reg;
                        count_w            = count_w + 2'd1;
                    end
                    else
                    begin
                        collecting_next   = 1'b1;
                        bytes_needed_next = lead_need;
                        partial_next      = lead_value;
                        min_class_next    = lead_class;
                        seq_start_next    = position_reg;
                    end
                end

                // flush of an unfinished sequence at end of text
                if (end_of_text && collecting_next)
                begin
                    unit_w[count_w[0]] = REPL_UNIT;
                    offs_w[count_w[0]] = seq_start_next;
                    count_w            = count_w + 2'd1;
                end
            end

            ENC_UTF16LE, ENC_UTF16BE:
            begin
                case (held_count_reg)
                    2'd0:
                    begin
                        held_byte_next  = byte_in;
                        held_count_next = 2'd1;
                        seq_start_next  = position_reg;
                        if (end_of_text)
                        begin
                            held_count_next = 2'd0;
                            unit_w[0]       = REPL_UNIT;
                            offs_w[0]       = position_reg;
                            count_w         = 2'd1;
                        end
                    end
                    2'd1:
                    begin
                        held_count_next = 2'd0;
                        offs_w[0]       = seq_start_reg;
                        if (is_low_surrogate(pair_unit))
                        begin
                            unit_w[0] = REPL_UNIT;
                            count_w   = 2'd1;
                        end
                        else if (is_high_surrogate(pair_unit))
                        begin
                            held_count_next = 2'd2;
                            if (end_of_text)
                            begin
                                held_count_next = 2'd0;
                                unit_w[0]       = REPL_UNIT;
                                count_w         = 2'd1;
                            end
                        end
                        else
                        begin
                            unit_w[0] = pair_unit;
                            count_w   = 2'd1;
                        end
                    end
                    2'd2:
                    begin
                        held_byte_next  = byte_in;
                        held_count_next = 2'd3;
                        if (end_of_text)
                        begin
                            held_count_next = 2'd0;
                            unit_w[0]       = REPL_UNIT;
                            offs_w[0]       = seq_start_reg;
                            unit_w[1]       = REPL_UNIT;
                            offs_w[1]       = pos_prev;
                            count_w         = 2'd2;
                        end
                    end
                    default:
                    begin
                        // high surrogate is answered whatever follows
                        unit_w[0]       = REPL_UNIT;
                        offs_w[0]       = seq_start_reg;
                        count_w         = 2'd1;
                        held_count_next = 2'd0;
                        if (!is_low_surrogate(pair_unit))
                        begin
                            // following unit decoded afresh from its own offset
                            seq_start_next = pos_prev;
                            if (is_high_surrogate(pair_unit))
                            begin
                                held_count_next = 2'd2;
                                if (end_of_text)
                                begin
                                    held_count_next = 2'd0;
                                    unit_w[1]       = REPL_UNIT;
                                    offs_w[1]       = pos_prev;
                                    count_w         = 2'd2;
                                end
                            end
                            else
                            begin
                                unit_w[1] = pair_unit;
                                offs_w[1] = pos_prev;
                                count_w   = 2'd2;
                            end
                        end
                    end
                endcase
            end

            default:
            begin
                unit_w[0] = REPL_UNIT;
                offs_w[0] = position_reg;
                count_w   = 2'd1;
            end
        endcase

        if (end_of_text)
        begin
            collecting_next = 1'b0;
            held_count_next = 2'd0;
        end
    end

    // line numbers of both words and the count left behind
    assign nl_first    = (count_w != 2'd0) && (unit_w[0] == NEWLINE_UNIT);
    assign nl_second   = (count_w == 2'd2) && (unit_w[1] == NEWLINE_UNIT);
    assign line_inc1   = (line_reg == LINE_MAX) ? LINE_MAX : line_reg + 32'd1;
    assign line_inc2   = (line_reg >= LINE_MAX - 32'd1) ? LINE_MAX : line_reg + 32'd2;
    assign line_second = nl_first ? line_inc1 : line_reg;

    always_comb
    begin
        if (end_of_text)
        begin
            line_next = start_line_reg;
        end
        else if (nl_first && nl_second)
        begin
            line_next = line_inc2;
        end
        else if (nl_first || nl_second)
        begin
            line_next = line_inc1;
        end
        else
        begin
            line_next = line_reg;
        end
    end

    assign position_next = end_of_text ? OFFSET_BITS'(start_offset_reg)
                                       : position_reg + OFFSET_BITS'(1);

    // result words handed to the buffer
    always_comb
    begin
        pair.count              = count_w;
        pair.first.code_unit    = unit_w[0];
        pair.first.unit_offset  = 32'(offs_w[0]);
        pair.first.line_number  = line_reg;
        pair.first.last_of_run  = (count_w == 2'd1);
        pair.second.code_unit   = unit_w[1];
        pair.second.unit_offset = 32'(offs_w[1]);
        pair.second.line_number = line_second;
        pair.second.last_of_run = 1'b1;
    end

    // state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            encoding_reg     <= ENC_UTF8;
            start_offset_reg <= '0;
            start_line_reg   <= LINE_FIRST;
            collecting_reg   <= 1'b0;
            bytes_needed_reg <= '0;
            partial_reg      <= '0;
            min_class_reg    <= '0;
            held_byte_reg    <= '0;
            held_count_reg   <= '0;
            seq_start_reg    <= '0;
            position_reg     <= '0;
            line_reg         <= LINE_FIRST;
        end
        else
        begin
            if (accept)
            begin
                collecting_reg   <= collecting_next;
                bytes_needed_reg <= bytes_needed_next;
                partial_reg      <= partial_next;
                min_class_reg    <= min_class_next;
                held_byte_reg    <= held_byte_next;
                held_count_reg   <= held_count_next;
                seq_start_reg    <= seq_start_next;
                position_reg     <= position_next;
                line_reg         <= line_next;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_ENCODING:
                    begin
                        encoding_reg   <= encoding_t'(cfg_data[1:0]);
                        collecting_reg <= 1'b0;
                        held_count_reg <= '0;
                    end
                    REG_START_OFFSET:
                    begin
                        start_offset_reg <= cfg_data;
                        position_reg     <= OFFSET_BITS'(cfg_data);
                    end
                    REG_START_LINE:
                    begin
                        // a line number of zero reads as one
                        start_line_reg <= (cfg_data == '0) ? LINE_FIRST : cfg_data;
                        line_reg       <= (cfg_data == '0) ? LINE_FIRST : cfg_data;
                    end
                    default:
                    begin
                        start_offset_reg <= start_offset_reg;
                    end
                endcase
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/tsd_result_buffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsd_result_buffer
// Two-word result register that takes a pair of words from the decoder and
// hands them out one word at a time.
// ----------------------------------------------------------------------------
module tsd_result_buffer (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire tsd_pkg::result_pair_t pair,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output tsd_pkg::result_t           head
);
    import tsd_pkg::*;

    logic [1:0] count_reg, count_next;
    result_t    head_reg,  head_next;
    result_t    tail_reg,  tail_next;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign head      = head_reg;

    // room for a full pair once this cycle's word has gone
    assign in_ready = (count_reg == 2'd0) || ((count_reg == 2'd1) && out_ready);

    // next occupancy and contents
    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        if (pop)
        begin
            head_next  = tail_reg;
            count_next = count_reg - 2'd1;
        end
        if (push)
        begin
            head_next  = pair.first;
            tail_next  = pair.second;
            count_next = pair.count;
        end
    end

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // word storage
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule
`default_nettype wire

FILE: rtl/core/text_stream_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_stream_decoder
// Decodes a UTF-8 or UTF-16 byte stream into 16-bit BMP code units, each
// tagged with the byte offset where it began and its line number.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  cfg      | cfg_write              | cfg_index, cfg_data
//  in       | in_valid / in_ready    | byte_in, end_of_text
//  out      | out_valid / out_ready  | code_unit, unit_offset, line_number,
//           |                        | last_of_run
//
//  One byte is taken per cycle while in_ready is high; its first word appears
//  on the output the cycle after. A byte that yields two words fills the
//  two-word result register; the next byte waits while the second word drains.
//  Input is open only when the result register is empty or its one word leaves
//  this cycle, so a word stalled on out_ready holds input off.
//  After reset: UTF-8, start offset 0, start line 1, nothing pending.
//
module text_stream_decoder #(
    parameter int OFFSET_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  byte_in,
    input  wire logic        end_of_text,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      code_unit,
    output logic [31:0]      unit_offset,
    output logic [31:0]      line_number,
    output logic             last_of_run
);
    import tsd_pkg::*;

    logic         accept;
    result_pair_t pair;
    result_t      head;

    assign accept = in_valid && in_ready;

    // decode state and per-byte logic
    tsd_decoder #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_decoder (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .byte_in     (byte_in),
        .end_of_text (end_of_text),
        .pair        (pair)
    );

    // result register
    tsd_result_buffer u_result_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .pair      (pair),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign code_unit   = head.code_unit;
    assign unit_offset = head.unit_offset;
    assign line_number = head.line_number;
    assign last_of_run = head.last_of_run;

    // never more than two words for one byte
    assert property (@(posedge clk) disable iff (!rst_n)
        pair.count != 2'd3)
        else $error("decoder produced more than two words for one byte");

    // an empty result register always takes a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input held off with empty result register");

    // first word of a pair taken means the second one follows at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_of_run) |=> out_valid)
        else $error("second word of a pair lost");

    // with output stalled, input is only open when nothing is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready && !out_ready) |-> !out_valid)
        else $error("input open while a stalled word waits");

endmodule
`default_nettype wire

FILE: test/decode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decode_checker
// Watches the configuration port and both data channels of the text stream
// decoder. Every accepted byte is run through a local decoder that keeps its
// own copy of the registers and sequence state. The words it produces are
// queued, and each word the block hands out is compared field by field with
// the oldest one waiting. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
module decode_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [7:0]  byte_in,
    input  wire logic        end_of_text,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [15:0] code_unit,
    input  wire logic [31:0] unit_offset,
    input  wire logic [31:0] line_number,
    input  wire logic        last_of_run,
    output int               mismatch_count,
    output int               units_outstanding
);
    import tsd_pkg::*;

    // register copies
    encoding_t   cur_encoding = ENC_UTF8;
    logic [31:0] base_offset  = '0;
    logic [31:0] base_line    = LINE_FIRST;

    // decoding state
    logic        in_sequence   = 1'b0;
    logic [1:0]  cont_left     = '0;
    logic [20:0] code_acc      = '0;
    logic [1:0]  size_class    = '0;
    logic [23:0] latched_bytes = '0;
    logic [1:0]  latched_count = '0;
    logic [31:0] seq_offset    = '0;
    logic [31:0] next_offset   = '0;
    logic [31:0] cur_line      = LINE_FIRST;

    result_t     step_units [$];
    result_t     expected_units [$];

    initial
    begin
        mismatch_count    = 0;
        units_outstanding = 0;
    end

    function automatic void drop_sequence();
        in_sequence   = 1'b0;
        cont_left     = '0;
        code_acc      = '0;
        size_class    = '0;
        latched_bytes = '0;
        latched_count = '0;
    endfunction

    function automatic void clear_model();
        cur_encoding = ENC_UTF8;
        base_offset  = '0;
        base_line    = LINE_FIRST;
        drop_sequence();
        seq_offset   = '0;
        next_offset  = '0;
        cur_line     = LINE_FIRST;
        expected_units.delete();
    endfunction

    // one decoded word; a newline moves the line count on, saturating
    function automatic void put_unit(input logic [15:0] unit, input logic [31:0] offset);
        result_t w;
        w.code_unit   = unit;
        w.unit_offset = offset;
        w.line_number = cur_line;
        w.last_of_run = 1'b0;
        step_units.push_back(w);
        if (unit == NEWLINE_UNIT && cur_line != LINE_MAX)
        begin
            cur_line = cur_line + 32'd1;
        end
    endfunction

    // utf-8 byte outside a sequence: ascii, a lead byte, or garbage
    function automatic void utf8_start(input logic [7:0] b, input logic [31:0] pos);
        if (b < ASCII_LIMIT)
        begin
            put_unit({8'h00, b}, pos);
            return;
        end
        if ((b & LEAD2_MASK) == LEAD2_TAG)
        begin
            cont_left  = 2'd1;
            code_acc   = {16'd0, b[4:0]};
            size_class = 2'd0;
        end
        else if ((b & LEAD3_MASK) == LEAD3_TAG)
        begin
            cont_left  = 2'd2;
            code_acc   = {17'd0, b[3:0]};
            size_class = 2'd1;
        end
        else if ((b & LEAD4_MASK) == LEAD4_TAG)
        begin
            cont_left  = 2'd3;
            code_acc   = {18'd0, b[2:0]};
            size_class = 2'd2;
        end
        else
        begin
            put_unit(REPL_UNIT, pos);
            return;
        end
        in_sequence = 1'b1;
        seq_offset  = pos;
    endfunction

    function automatic void utf8_byte(input logic [7:0] b, input logic eot,
                                      input logic [31:0] pos);
        logic [20:0] floor_cp;
        if (in_sequence)
        begin
            if ((b & CONT_MASK) == CONT_TAG)
            begin
                code_acc  = {code_acc[14:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0)
                begin
                    floor_cp = (size_class == 2'd0) ? MIN_TWO_BYTE :
                               (size_class == 2'd1) ? MIN_THREE_BYTE : MIN_FOUR_BYTE;
                    in_sequence = 1'b0;
                    // overlong, beyond the bmp or a surrogate
                    if (code_acc < floor_cp || code_acc > BMP_LAST ||
                        (code_acc >= SURR_FIRST && code_acc <= SURR_LAST))
                    begin
                        put_unit(REPL_UNIT, seq_offset);
                    end
                    else
                    begin
                        put_unit(code_acc[15:0], seq_offset);
                    end
                end
            end
            else
            begin
                // broken sequence, then the byte is decoded afresh
                in_sequence = 1'b0;
                put_unit(REPL_UNIT, seq_offset);
                utf8_start(b, pos);
            end
        end
        else
        begin
            utf8_start(b, pos);
        end
        if (eot && in_sequence)
        begin
            in_sequence = 1'b0;
            put_unit(REPL_UNIT, seq_offset);
        end
    endfunction

    function automatic logic [15:0] join_bytes(input logic [7:0] first_byte,
                                               input logic [7:0] second_byte);
        if (cur_encoding == ENC_UTF16LE)
        begin
            return {second_byte, first_byte};
        end
        return {first_byte, second_byte};
    endfunction

    // a complete utf-16 unit starting at seq_offset; a high surrogate is held
    function automatic void utf16_unit(input logic [15:0] unit);
        if (unit >= LOW_SURR_FIRST && unit <= LOW_SURR_LAST)
        begin
            drop_sequence();
            put_unit(REPL_UNIT, seq_offset);
        end
        else if (unit < HIGH_SURR_FIRST || unit > HIGH_SURR_LAST)
        begin
            drop_sequence();
            put_unit(unit, seq_offset);
        end
        else
        begin
            in_sequence   = 1'b1;
            latched_bytes = {8'h00, unit};
            latched_count = 2'd2;
        end
    endfunction

    function automatic void utf16_byte(input logic [7:0] b, input logic eot,
                                       input logic [31:0] pos);
        logic [15:0] follow;
        case (latched_count)
            2'd0:
            begin
                in_sequence   = 1'b1;
                latched_bytes = {16'h0000, b};
                latched_count = 2'd1;
                seq_offset    = pos;
                if (eot)
                begin
                    drop_sequence();
                    put_unit(REPL_UNIT, seq_offset);
                end
                return;
            end
            2'd1:
            begin
                utf16_unit(join_bytes(latched_bytes[7:0], b));
            end
            2'd2:
            begin
                latched_bytes = {b, latched_bytes[15:0]};
                latched_count = 2'd3;
                // high surrogate plus one lone byte at end of text
                if (eot)
                begin
                    drop_sequence();
                    put_unit(REPL_UNIT, seq_offset);
                    put_unit(REPL_UNIT, pos - 32'd1);
                end
                return;
            end
            default:
            begin
                follow = join_bytes(latched_bytes[23:16], b);
                put_unit(REPL_UNIT, seq_offset);
                // a valid pair is a single replacement
                if (follow >= LOW_SURR_FIRST && follow <= LOW_SURR_LAST)
                begin
                    drop_sequence();
                    return;
                end
                seq_offset = pos - 32'd1;
                utf16_unit(follow);
            end
        endcase
        if (eot && latched_count == 2'd2)
        begin
            drop_sequence();
            put_unit(REPL_UNIT, seq_offset);
        end
    endfunction

    // expected words for one accepted byte, the last one flagged
    function automatic void predict_byte(input logic [7:0] b, input logic eot);
        logic [31:0] pos;
        result_t     w;
        pos = next_offset;
        step_units.delete();
        case (cur_encoding)
            ENC_UTF8:                 utf8_byte(b, eot, pos);
            ENC_UTF16LE, ENC_UTF16BE: utf16_byte(b, eot, pos);
            default:                  put_unit(REPL_UNIT, pos);
        endcase
        next_offset = next_offset + 32'd1;
        if (eot)
        begin
            drop_sequence();
            next_offset = base_offset;
            cur_line    = (base_line == 32'd0) ? LINE_FIRST : base_line;
        end
        foreach (step_units[i])
        begin
            w             = step_units[i];
            w.last_of_run = (i == step_units.size() - 1);
            expected_units.push_back(w);
        end
    endfunction

    function automatic void apply_write(input logic [1:0] idx, input logic [31:0] data);
        case (idx)
            REG_ENCODING:
            begin
                cur_encoding = encoding_t'(data[1:0]);
                drop_sequence();
            end
            REG_START_OFFSET:
            begin
                base_offset = data;
                next_offset = data;
            end
            REG_START_LINE:
            begin
                base_line = data;
                cur_line  = (data == 32'd0) ? LINE_FIRST : data;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count = mismatch_count + 1;
            $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
        end
    endfunction

    function automatic void check_unit();
        result_t want;
        if (expected_units.size() == 0)
        begin
            mismatch_count = mismatch_count + 1;
            $display("%0t ns: expected no word, got code_unit %h unit_offset %h",
                     $time, code_unit, unit_offset);
            $display("%0t ns: line_number %h last_of_run %b",
                     $time, line_number, last_of_run);
            return;
        end
        want = expected_units.pop_front();
        check_field("code_unit", {16'h0000, want.code_unit}, {16'h0000, code_unit});
        check_field("unit_offset", want.unit_offset, unit_offset);
        check_field("line_number", want.line_number, line_number);
        check_field("last_of_run", {31'd0, want.last_of_run}, {31'd0, last_of_run});
    endfunction

    // register writes, accepted bytes and accepted words at each edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_model();
        end
        else
        begin
            if (cfg_write)
            begin
                apply_write(cfg_index, cfg_data);
            end
            if (in_valid && in_ready)
            begin
                predict_byte(byte_in, end_of_text);
            end
            if (out_valid && out_ready)
            begin
                check_unit();
            end
        end
        units_outstanding = expected_units.size();
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the text stream decoder through a directed set of malformed and
// boundary sequences in utf-8 and utf-16, then random phases of mostly
// well-formed text in every encoding under several register settings,
// including wrapping offsets and a saturating line count. Both channels
// idle at random. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    import tsd_pkg::*;

    localparam logic [1:0] REG_SPARE      = 2'd3;
    localparam int         IDLE_PERCENT   = 16;
    localparam int         DRAIN_CYCLES   = 4;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         PHASES         = 8;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  byte_in;
    logic        end_of_text;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] code_unit;
    logic [31:0] unit_offset;
    logic [31:0] line_number;
    logic        last_of_run;

    int          mismatch_count;
    int          units_outstanding;
    int          stall_cycles = 0;
    int          bytes_sent   = 0;
    bit          calm         = 1'b0;

    // malformed utf-8: bad lead, stray continuation, overlong, surrogate,
    // beyond the bmp, broken sequence, sequence cut by end of text
    logic [7:0] utf8_cases [16] = '{8'h00, 8'hFF, 8'h80, 8'hC0, 8'h80, 8'hED, 8'hA0, 8'h80,
                                    8'hF0, 8'h9F, 8'h98, 8'h80, 8'hE2, 8'h41, 8'hE2, 8'h82};
    // utf-16 le: lone low surrogate, valid pair, high then a plain unit,
    // high plus one byte at end of text
    logic [7:0] utf16_cases [13] = '{8'h00, 8'hDC, 8'h3D, 8'hD8, 8'h00, 8'hDE, 8'h3D, 8'hD8,
                                     8'h41, 8'h00, 8'h3D, 8'hD8, 8'h41};

    encoding_t   phase_enc  [PHASES];
    logic [31:0] phase_off  [PHASES];
    logic [31:0] phase_line [PHASES];
    int          phase_len  [PHASES];

    text_stream_decoder u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .byte_in     (byte_in),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .code_unit   (code_unit),
        .unit_offset (unit_offset),
        .line_number (line_number),
        .last_of_run (last_of_run)
    );

    decode_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .byte_in           (byte_in),
        .end_of_text       (end_of_text),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .code_unit         (code_unit),
        .unit_offset       (unit_offset),
        .line_number       (line_number),
        .last_of_run       (last_of_run),
        .mismatch_count    (mismatch_count),
        .units_outstanding (units_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver stalls at random unless in a calm stretch
    always @(negedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // watchdog on cycles where neither channel moves a word
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // one byte, with random idle cycles ahead of it; returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic eot);
        while (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        byte_in     <= b;
        end_of_text <= eot;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        bytes_sent = bytes_sent + 1;
        @(negedge clk);
    endtask

    // hold off input until every expected word has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (units_outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // one utf-8 character, mostly well formed, sometimes overlong, cut or noise
    task automatic send_utf8_char();
        logic [7:0]  seq [4];
        logic [20:0] cp;
        int          len;
        int          kind;
        bit          eot;
        kind = $urandom_range(99);
        len  = 1;
        cp   = '0;
        if (kind < 35)
        begin
            cp = ($urandom_range(9) == 0) ? 21'h0A : 21'($urandom_range(127));
        end
        else if (kind < 55)
        begin
            len = 2;
            cp  = 21'($urandom_range(32'h7FF, 32'h80));
        end
        else if (kind < 75)
        begin
            len = 3;
            cp  = 21'($urandom_range(32'hFFFF, 32'h800));
        end
        else if (kind < 82)
        begin
            len = 4;
            cp  = 21'($urandom_range(32'h1FFFFF, 32'h10000));
        end
        else if (kind < 88)
        begin
            len = $urandom_range(4, 2);
            cp  = (len == 2) ? 21'($urandom_range(127)) :
                  (len == 3) ? 21'($urandom_range(32'h7FF)) : 21'($urandom_range(32'hFFFF));
        end
        case (len)
            1: seq[0] = cp[7:0];
            2:
            begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        // raw noise byte
        if (kind >= 88)
        begin
            seq[0] = 8'($urandom_range(255));
        end
        // truncated sequence
        if (len > 1 && $urandom_range(19) == 0)
        begin
            len = $urandom_range(len - 1, 1);
        end
        eot = ($urandom_range(39) == 0);
        for (int i = 0; i < len; i++)
        begin
            send_byte(seq[i], eot && (i == len - 1));
        end
    endtask

    // one utf-16 character in the given byte order, with surrogate cases
    task automatic send_utf16_char(input encoding_t enc);
        logic [15:0] units [2];
        int          count;
        int          kind;
        bit          eot;
        kind  = $urandom_range(99);
        count = 1;
        eot   = ($urandom_range(39) == 0);
        if (kind >= 90)
        begin
            // stray byte, knocks the unit alignment over
            send_byte(8'($urandom_range(255)), eot);
            return;
        end
        if (kind < 55)
        begin
            if ($urandom_range(9) == 0)
            begin
                units[0] = NEWLINE_UNIT;
            end
            else if ($urandom_range(1) == 0)
            begin
                units[0] = 16'($urandom_range(32'hD7FF));
            end
            else
            begin
                units[0] = 16'($urandom_range(32'hFFFF, 32'hE000));
            end
        end
        else if (kind < 72)
        begin
            count    = 2;
            units[0] = 16'($urandom_range(HIGH_SURR_LAST, HIGH_SURR_FIRST));
            units[1] = 16'($urandom_range(LOW_SURR_LAST, LOW_SURR_FIRST));
        end
        else if (kind < 80)
        begin
            units[0] = 16'($urandom_range(LOW_SURR_LAST, LOW_SURR_FIRST));
        end
        else
        begin
            units[0] = 16'($urandom_range(HIGH_SURR_LAST, HIGH_SURR_FIRST));
        end
        for (int i = 0; i < count; i++)
        begin
            if (enc == ENC_UTF16LE)
            begin
                send_byte(units[i][7:0], 1'b0);
                send_byte(units[i][15:8], eot && (i == count - 1));
            end
            else
            begin
                send_byte(units[i][15:8], 1'b0);
                send_byte(units[i][7:0], eot && (i == count - 1));
            end
        end
    endtask

    initial
    begin
        encoding_t prev_enc;
        int        phase_start;
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = REG_ENCODING;
        cfg_data    = '0;
        in_valid    = 1'b0;
        byte_in     = '0;
        end_of_text = 1'b0;

        // register settings per phase, extremes among them
        phase_enc[0] = ENC_UTF8;        phase_off[0] = 32'h0000_0000;
        phase_line[0] = 32'd0;          phase_len[0] = 200;
        phase_enc[1] = ENC_UTF8;        phase_off[1] = 32'hFFFF_FFF8;
        phase_line[1] = 32'hFFFF_FFFE;  phase_len[1] = 130;
        phase_enc[2] = ENC_UTF16LE;     phase_off[2] = $urandom();
        phase_line[2] = $urandom();     phase_len[2] = 150;
        phase_enc[3] = ENC_UTF16BE;     phase_off[3] = 32'hFFFF_FFFF;
        phase_line[3] = LINE_FIRST;     phase_len[3] = 150;
        phase_enc[4] = ENC_UTF16BE;     phase_off[4] = 32'h0000_0000;
        phase_line[4] = LINE_MAX;       phase_len[4] = 80;
        phase_enc[5] = ENC_UNSUPPORTED; phase_off[5] = $urandom();
        phase_line[5] = $urandom();     phase_len[5] = 30;
        phase_enc[6] = ENC_UTF8;        phase_off[6] = $urandom();
        phase_line[6] = $urandom();     phase_len[6] = 110;
        phase_enc[7] = ENC_UTF16LE;     phase_off[7] = 32'hFFFF_FFFE;
        phase_line[7] = LINE_MAX;       phase_len[7] = 70;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed cases at the reset settings, then in utf-16 le
        for (int i = 0; i < 16; i++)
        begin
            send_byte(utf8_cases[i], i == 15);
        end
        drain();
        write_reg(REG_ENCODING, 32'(ENC_UTF16LE));
        prev_enc = ENC_UTF16LE;
        for (int i = 0; i < 13; i++)
        begin
            send_byte(utf16_cases[i], i == 12);
        end

        // random phases; a pending sequence may survive an offset or line write
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            if (phase_enc[p] != prev_enc)
            begin
                write_reg(REG_ENCODING, 32'(phase_enc[p]));
            end
            prev_enc = phase_enc[p];
            write_reg(REG_START_OFFSET, phase_off[p]);
            write_reg(REG_START_LINE, phase_line[p]);
            if (p == 5)
            begin
                write_reg(REG_SPARE, 32'hFFFF_FFFF);
            end
            calm        = (p == 0);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < phase_len[p])
            begin
                case (phase_enc[p])
                    ENC_UTF8:                 send_utf8_char();
                    ENC_UTF16LE, ENC_UTF16BE: send_utf16_char(phase_enc[p]);
                    default:
                    begin
                        send_byte(8'($urandom_range(255)), $urandom_range(19) == 0);
                    end
                endcase
            end
        end
        calm = 1'b0;
        drain();

        if (mismatch_count == 0 && units_outstanding == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
